@@ sv/postfix_expression_evaluator_defines.svh @@
// Assertion macros for the checker file.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication.
`define PFE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pfe_pkg.sv @@
`default_nettype none

package pfe_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_UNDERFLOW = 3'd1,
        STAT_UNKNOWN   = 3'd2,
        STAT_DIVZERO   = 3'd3,
        STAT_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CK_DIGIT,
        CK_ADD,
        CK_SUB,
        CK_MUL,
        CK_DIV,
        CK_OTHER
    } t_char_kind;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_PUSH,
        WR_ADD,
        WR_SUB,
        WR_MD
    } t_wr_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MULDIV,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic    cap;
        t_wr_sel wr_sel;
        logic    md_start;
        logic    md_div;
        logic    err_set;
        t_status err_code;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_char_kind kind;
        logic       last;
        logic       err_ok;
        logic       full;
        logic       lt2;
        logic       rhs_zero;
        logic       md_done;
        logic       out_free;
    } t_dp_stat;

    function automatic t_char_kind char_kind(input logic [CHAR_W-1:0] c);
        t_char_kind k;
        if (c >= CH_0 && c <= CH_9) k = CK_DIGIT;
        else if (c == CH_PLUS)      k = CK_ADD;
        else if (c == CH_MINUS)     k = CK_SUB;
        else if (c == CH_STAR)      k = CK_MUL;
        else if (c == CH_SLASH)     k = CK_DIV;
        else                        k = CK_OTHER;
        return k;
    endfunction

endpackage

`default_nettype wire

@@ sv/pfe_ctrl.sv @@
`default_nettype none

module pfe_ctrl
    import pfe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    t_state after_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        after_char = i_stat.last ? S_READ : S_IDLE;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = after_char;
                // a latched error swallows everything up to the end marker
                priority if (!i_stat.err_ok) begin
                    o_cmd.wr_sel = WR_NONE;
                end else if (i_stat.kind == CK_DIGIT) begin
                    if (i_stat.full) begin
                        o_cmd.err_set  = 1'b1;
                        o_cmd.err_code = STAT_OVERFLOW;
                    end else begin
                        o_cmd.wr_sel = WR_PUSH;
                    end
                end else if (i_stat.kind == CK_OTHER) begin
                    o_cmd.err_set  = 1'b1;
                    o_cmd.err_code = STAT_UNKNOWN;
                end else if (i_stat.lt2) begin
                    o_cmd.err_set  = 1'b1;
                    o_cmd.err_code = STAT_UNDERFLOW;
                end else if (i_stat.kind == CK_ADD) begin
                    o_cmd.wr_sel = WR_ADD;
                end else if (i_stat.kind == CK_SUB) begin
                    o_cmd.wr_sel = WR_SUB;
                end else if (i_stat.kind == CK_MUL) begin
                    o_cmd.md_start = 1'b1;
                    n_state        = S_MULDIV;
                end else if (i_stat.rhs_zero) begin
                    o_cmd.err_set  = 1'b1;
                    o_cmd.err_code = STAT_DIVZERO;
                end else begin
                    o_cmd.md_start = 1'b1;
                    o_cmd.md_div   = 1'b1;
                    n_state        = S_MULDIV;
                end
            end
            S_MULDIV: begin
                if (i_stat.md_done) begin
                    o_cmd.wr_sel = WR_MD;
                    n_state      = after_char;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/pfe_muldiv.sv @@
`default_nettype none

module pfe_muldiv
    import pfe_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_div,
    input  wire logic [DATA_WIDTH-1:0] i_lhs,
    input  wire logic [DATA_WIDTH-1:0] i_rhs,
    output logic                       o_done,
    output logic [DATA_WIDTH-1:0]      o_result
);

    localparam int STEP_W = $clog2(DATA_WIDTH + 1);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_div;
    logic                  r_neg;
    logic [STEP_W-1:0]     r_step;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_x;
    logic [DATA_WIDTH-1:0] r_y;

    logic [DATA_WIDTH-1:0] lhs_mag;
    logic [DATA_WIDTH-1:0] rhs_mag;
    logic [DATA_WIDTH:0]   trial;

    assign lhs_mag = i_lhs[DATA_WIDTH-1] ? (~i_lhs + 1'b1) : i_lhs;
    assign rhs_mag = i_rhs[DATA_WIDTH-1] ? (~i_rhs + 1'b1) : i_rhs;
    assign trial   = {r_acc, r_x[DATA_WIDTH-1]} - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_div;
            r_neg  <= i_lhs[DATA_WIDTH-1] ^ i_rhs[DATA_WIDTH-1];
            r_step <= STEP_W'(DATA_WIDTH);
            r_acc  <= '0;
            r_x    <= i_div ? lhs_mag : i_lhs;
            r_y    <= i_div ? rhs_mag : i_rhs;
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_div) begin
                // restoring divide: one quotient bit per cycle
                if (!trial[DATA_WIDTH]) begin
                    r_acc <= trial[DATA_WIDTH-1:0];
                    r_x   <= {r_x[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_acc <= {r_acc[DATA_WIDTH-2:0], r_x[DATA_WIDTH-1]};
                    r_x   <= {r_x[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                // shift-add multiply, low word only
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[DATA_WIDTH-2:0], 1'b0};
                r_y <= {1'b0, r_y[DATA_WIDTH-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (~r_x + 1'b1) : r_x) : r_acc;

endmodule

`default_nettype wire

@@ sv/pfe_dpath.sv @@
`default_nettype none

module pfe_dpath
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_data,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_stat       o_stat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_stack [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_top;
    logic [DATA_WIDTH-1:0] r_rd_nxt;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    t_status               r_err;
    logic                  r_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W-1:0]      cnt_m2;
    logic [ADDR_W-1:0]     top_addr;
    logic [ADDR_W-1:0]     nxt_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  md_done;
    logic [DATA_WIDTH-1:0] md_result;
    logic [3:0]            digit;

    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign cnt_m2   = r_cnt - CNT_W'(2);
    assign top_addr = (r_cnt == '0) ? '0 : cnt_m1[ADDR_W-1:0];
    assign nxt_addr = (r_cnt < CNT_W'(2)) ? '0 : cnt_m2[ADDR_W-1:0];
    assign digit    = 4'(r_char - CH_0);

    pfe_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.md_start),
        .i_div    (i_cmd.md_div),
        .i_lhs    (r_rd_nxt),
        .i_rhs    (r_rd_top),
        .o_done   (md_done),
        .o_result (md_result)
    );

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = nxt_addr;
        wr_data = md_result;
        n_cnt   = cnt_m1;
        unique case (i_cmd.wr_sel)
            WR_PUSH: begin
                wr_addr = r_cnt[ADDR_W-1:0];
                wr_data = DATA_WIDTH'(digit);
                n_cnt   = r_cnt + CNT_W'(1);
            end
            WR_ADD:  wr_data = r_rd_nxt + r_rd_top;
            WR_SUB:  wr_data = r_rd_nxt - r_rd_top;
            WR_MD:   wr_data = md_result;
            default: begin
                wr_en = 1'b0;
                n_cnt = r_cnt;
            end
        endcase
    end

    always_comb begin
        n_out = '0;
        if (r_err != STAT_OK) begin
            n_out.status = r_err;
        end else if (r_cnt == '0) begin
            n_out.status = STAT_UNDERFLOW;
        end else begin
            n_out.status = STAT_OK;
            n_out.value  = VALUE_W'($signed(r_rd_top));
        end
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        r_rd_top <= r_stack[top_addr];
        r_rd_nxt <= r_stack[nxt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_char <= i_in_data.char_code;
            r_last <= i_in_data.end_of_expr;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_err       <= STAT_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_cnt <= '0;
                r_err <= STAT_OK;
            end else begin
                r_cnt <= n_cnt;
                if (i_cmd.err_set) begin
                    r_err <= i_cmd.err_code;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.kind     = char_kind(r_char);
        o_stat.last     = r_last;
        o_stat.err_ok   = (r_err == STAT_OK);
        o_stat.full     = (r_cnt >= CNT_W'(STACK_DEPTH));
        o_stat.lt2      = (r_cnt < CNT_W'(2));
        o_stat.rhs_zero = (r_rd_top == '0);
        o_stat.md_done  = md_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ sv/postfix_expression_evaluator.sv @@
// Postfix expression evaluator.
// Input channel (i_in_valid / o_in_ready / i_in_data): one ASCII character per
// transfer, end_of_expr set on the last character of an expression. Digits push,
// + - * / pop two operands and push the wrapped result; / truncates toward zero.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transfer per
// expression, carrying the top of stack and a status (ok, underflow, unknown
// character, divide by zero, overflow). The first error is latched and the
// rest of the expression is ignored; value reads 0 on any error.
// A digit, + or -, and any character that meets or raises an error is done in
// the execute state; * and a nonzero / wait in the mul/div state for the shared
// shift-add / restoring-divide unit that retires one bit per cycle. The end
// character then goes on to read the new top of stack from the two-read-port
// stack memory and to load the output register, which raises o_out_valid.
// Reset (synchronous, active low) empties the stack, clears the error and drops
// o_out_valid. Stack entries hold no reset value; only written ones are read.
// A stalled receiver holds the result in the output register; characters keep
// being taken until the next end character, which waits for the register.
`default_nettype none

module postfix_expression_evaluator
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    // command and status between sequencer and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: accept, execute, iterate mul/div, read top, deliver
    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // stack memory, count, error latch, arithmetic and output register
    pfe_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ sv/pfe_checker.sv @@
`default_nettype none

`include "postfix_expression_evaluator_defines.svh"

module pfe_checker
    import pfe_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    logic in_take;
    logic out_stall;
    logic out_err;

    assign in_take   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_err   = o_out_valid && (o_out_data.status != STAT_OK);

    // a stalled result holds
    `PFE_ASSERT_NXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data), "result changed")

    // input is not ready in the cycle after a character transfer
    `PFE_ASSERT_NXT(a_busy_after_take, in_take, !o_in_ready, "input taken back to back")

    // no result can appear right behind a character transfer
    `PFE_ASSERT_NXT(a_no_early_result, in_take, !$rose(o_out_valid), "early result")

    // error results carry a zero value
    `PFE_ASSERT_IMP(a_err_value_zero, out_err, o_out_data.value == 0, "error with nonzero value")

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);

`default_nettype wire
